### design/imhq_pkg.sv
package imhq_pkg;

  // field widths of the stream items
  localparam int unsigned ActW    = 2;
  localparam int unsigned KeyPW   = 32;
  localparam int unsigned HdPW    = 6;
  localparam int unsigned StatW   = 3;
  localparam int unsigned CntPW   = 7;
  localparam int unsigned LimW    = 7;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // operation codes on the input stream
  typedef enum logic [ActW-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_DEC    = 2'd2,
    ACT_IGNORE = 2'd3
  } act_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DEAD    = 3'd3,
    ST_KEY_INC = 3'd4
  } status_e;

  // decoded command handed from front to back
  typedef struct packed {
    act_e              act;
    logic [KeyPW-1:0]  key;
    logic [HdPW-1:0]   hd;
  } cmd_t;

  // result beat handed from back to the output stream
  typedef struct packed {
    logic [CntPW-1:0]  cnt;
    logic [HdPW-1:0]   hd;
    logic [KeyPW-1:0]  key;
    status_e           status;
  } res_t;

endpackage

### design/indexed_min_heap_queue.sv
// Indexed binary min-heap priority queue. Each input beat carries one
// operation (enqueue, dequeue minimum, decrease key, or an ignored code) and
// yields exactly one result beat with status, key, handle and the entry count
// afterwards. Enqueue hands out the lowest free handle. A two-entry command
// queue takes beats while the heap engine works; the engine runs one operation
// at a time. An operation that is refused or ignored goes straight to the
// result; a decrease first reads the entry's position and key and is refused
// if the new key is larger. Enqueue climbs the new entry up from the last
// slot, and an accepted decrease climbs the entry up from its slot. Dequeue
// returns the root; unless that empties the heap, the last entry moves to the
// root and sinks toward a leaf. Each level costs one registered read of the
// heap memory and one compare. A finished result can wait on m_axis_tready,
// and the engine holds until the output register is free. The user must write
// the capacity limit through cfg_we_i only while idle; the block does not enforce it.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // action[1:0], key[33:2], handle[39:34]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[2:0], key_out[34:3], handle_out[40:35], count[47:41]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [LimW-1:0]     cfg_wdata_i
);

  localparam int unsigned IW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LW    = (CNT_W > LimW) ? CNT_W : LimW;

  logic [LimW-1:0]  lim_q;
  logic [LW-1:0]    lim_w, lim_c;
  logic [CNT_W-1:0] limit;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  res_t             res;

  // capacity limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimW'(64);
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  // clamp limit into one to capacity
  always_comb begin
    lim_w = LW'(lim_q);
    if (lim_w == '0) begin
      lim_c = LW'(1);
    end else if (lim_w > LW'(CAPACITY)) begin
      lim_c = LW'(CAPACITY);
    end else begin
      lim_c = lim_w;
    end
  end
  assign limit = CNT_W'(lim_c);

  imhq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  imhq_back #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .IW        (IW),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .limit_i     (limit),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // pack the result beat
  assign m_axis_tdata = {res.cnt, res.hd, res.key, res.status};

endmodule

### design/imhq_front.sv
module imhq_front
  import imhq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_ready_i
);

  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;
  logic       push, pop;
  cmd_t       dec;

  // decode an input beat into a command
  always_comb begin
    dec.act = act_e'(s_axis_tdata[1:0]);
    dec.key = s_axis_tdata[33:2];
    dec.hd  = s_axis_tdata[39:34];
  end

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = fifo_q[rp_q];

  // two-entry command queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= dec;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

### design/imhq_back.sv
module imhq_back
  import imhq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned IW        = $clog2(CAPACITY),
  parameter int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_ready_o,
  input  logic [CNT_W-1:0] limit_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int unsigned XW = IW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DQ_RD  = 4'd1;
  localparam logic [3:0] S_DN     = 4'd2;
  localparam logic [3:0] S_DN_CMP = 4'd3;
  localparam logic [3:0] S_UP     = 4'd4;
  localparam logic [3:0] S_UP_CMP = 4'd5;
  localparam logic [3:0] S_DC_P   = 4'd6;
  localparam logic [3:0] S_DC_K   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [IW-1:0]        hd;
  } ent_t;

  // heap slots and handle positions
  ent_t          hmem [CAPACITY];
  logic [IW-1:0] pmem [CAPACITY];

  logic [3:0]          st_q, st_d;
  logic [IW-1:0]       idx_q, idx_d;
  ent_t                cur_q, cur_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CAPACITY-1:0] live_q, live_d;
  cmd_t                cmd_q, cmd_d;
  status_e             rst_q, rst_d;
  logic [KeyPW-1:0]    rkey_q, rkey_d;
  logic [HdPW-1:0]     rhd_q, rhd_d;
  logic                ov_q, ov_d;
  res_t                out_q, out_d;

  logic [IW-1:0]  ra0, ra1, pra;
  ent_t           rd0_q, rd1_q;
  logic [IW-1:0]  prd_q;
  logic           hwe, pwe;
  logic [IW-1:0]  hwa, pwa;
  ent_t           hwd;
  logic [IW-1:0]  pwd;

  logic [IW-1:0]        free_h;
  logic [KEY_WIDTH-1:0] kin;
  logic [IW:0]          lch, rch;
  logic [IW-1:0]        par;
  logic                 use_r;
  ent_t                 chd;
  logic                 fin_go;

  // lowest free handle
  always_comb begin
    free_h = IW'(CAPACITY - 1);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_h = IW'(i);
      end
    end
  end

  assign kin    = KEY_WIDTH'(cmd_q.key);
  assign lch    = {idx_q, 1'b1};
  assign rch    = lch + (IW+1)'(1);
  assign par    = (idx_q - IW'(1)) >> 1;
  assign use_r  = (XW'(rch) < XW'(cnt_q)) && (rd0_q.key >= rd1_q.key);
  assign chd    = use_r ? rd1_q : rd0_q;
  assign fin_go = (st_q == S_FIN) && (!ov_q || res_ready_i);

  assign cmd_ready_o = (st_q == S_IDLE);
  assign res_valid_o = ov_q;
  assign res_o       = out_q;

  // sequencer for one operation at a time
  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    live_d = live_q;
    cmd_d  = cmd_q;
    rst_d  = rst_q;
    rkey_d = rkey_q;
    rhd_d  = rhd_q;
    ra0    = idx_q;
    ra1    = idx_q;
    pra    = IW'(cmd_i.hd);
    hwe    = 1'b0;
    hwa    = idx_q;
    hwd    = cur_q;
    pwe    = 1'b0;
    pwa    = cur_q.hd;
    pwd    = idx_q;
    case (st_q)
      S_IDLE: begin
        ra0 = '0;
        ra1 = IW'(cnt_q - CNT_W'(1));
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          rst_d  = ST_OK;
          rkey_d = KeyPW'(KEY_WIDTH'(cmd_i.key));
          rhd_d  = '0;
          st_d   = S_FIN;
          case (cmd_i.act)
            ACT_ENQ: begin
              if (cnt_q >= limit_i) begin
                rst_d = ST_FULL;
              end else begin
                live_d[free_h] = 1'b1;
                cur_d.key      = KEY_WIDTH'(cmd_i.key);
                cur_d.hd       = free_h;
                idx_d          = IW'(cnt_q);
                cnt_d          = cnt_q + CNT_W'(1);
                rhd_d          = HdPW'(free_h);
                st_d           = S_UP;
              end
            end
            ACT_DEQ: begin
              if (cnt_q == '0) begin
                rst_d  = ST_EMPTY;
                rkey_d = '0;
              end else begin
                st_d = S_DQ_RD;
              end
            end
            ACT_DEC: begin
              rhd_d = cmd_i.hd;
              if ((32'(cmd_i.hd) >= 32'(CAPACITY)) || !live_q[IW'(cmd_i.hd)]) begin
                rst_d = ST_DEAD;
              end else begin
                st_d = S_DC_P;
              end
            end
            default: begin
              st_d = S_FIN;
            end
          endcase
        end
      end
      S_DQ_RD: begin
        rkey_d            = KeyPW'(rd0_q.key);
        rhd_d             = HdPW'(rd0_q.hd);
        live_d[rd0_q.hd]  = 1'b0;
        cnt_d             = cnt_q - CNT_W'(1);
        cur_d             = rd1_q;
        idx_d             = '0;
        st_d              = (cnt_q == CNT_W'(1)) ? S_FIN : S_DN;
      end
      S_DN: begin
        ra0 = lch[IW-1:0];
        ra1 = rch[IW-1:0];
        if (XW'(lch) >= XW'(cnt_q)) begin
          hwe  = 1'b1;
          pwe  = 1'b1;
          st_d = S_FIN;
        end else begin
          st_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        hwe = 1'b1;
        pwe = 1'b1;
        if (cur_q.key > chd.key) begin
          hwd   = chd;
          pwa   = chd.hd;
          idx_d = use_r ? rch[IW-1:0] : lch[IW-1:0];
          st_d  = S_DN;
        end else begin
          st_d = S_FIN;
        end
      end
      S_UP: begin
        ra0 = par;
        if (idx_q == '0) begin
          hwe  = 1'b1;
          pwe  = 1'b1;
          st_d = S_FIN;
        end else begin
          st_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        hwe = 1'b1;
        pwe = 1'b1;
        if (cur_q.key < rd0_q.key) begin
          hwd   = rd0_q;
          pwa   = rd0_q.hd;
          idx_d = par;
          st_d  = S_UP;
        end else begin
          st_d = S_FIN;
        end
      end
      S_DC_P: begin
        ra0   = prd_q;
        idx_d = prd_q;
        if (XW'(prd_q) >= XW'(cnt_q)) begin
          rst_d = ST_DEAD;
          st_d  = S_FIN;
        end else begin
          st_d = S_DC_K;
        end
      end
      S_DC_K: begin
        if (kin > rd0_q.key) begin
          rst_d = ST_KEY_INC;
          st_d  = S_FIN;
        end else begin
          cur_d.key = kin;
          cur_d.hd  = rd0_q.hd;
          st_d      = S_UP;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // output register in front of the result stream
  always_comb begin
    ov_d  = ov_q;
    out_d = out_q;
    if (fin_go) begin
      ov_d         = 1'b1;
      out_d.status = rst_q;
      out_d.key    = rkey_q;
      out_d.hd     = rhd_q;
      out_d.cnt    = CntPW'(cnt_q);
    end else if (res_ready_i) begin
      ov_d = 1'b0;
    end
  end

  // heap and position memories, registered reads
  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hmem[hwa] <= hwd;
    end
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    rd0_q <= hmem[ra0];
    rd1_q <= hmem[ra1];
    prd_q <= pmem[pra];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    cmd_q  <= cmd_d;
    rst_q  <= rst_d;
    rkey_q <= rkey_d;
    rhd_q  <= rhd_d;
    out_q  <= out_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      live_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      live_q <= live_d;
      ov_q   <= ov_d;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_live_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live_q) == int'(cnt_q))
    else $error("live handles disagree with entry count");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (st_q == S_IDLE) && ov_q)
    else $error("result not handed to output register");

  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !cmd_ready_o)
    else $error("command taken while busy");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import imhq_pkg::*;

  localparam int unsigned Slots = 64;

  typedef struct packed {
    act_e             act;
    logic [KeyPW-1:0] key;
    logic [HdPW-1:0]  hd;
  } op_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KeyPW-1:0] key;
    logic [HdPW-1:0]  hd;
    logic [CntPW-1:0] cnt;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [LimW-1:0]     cfg_wdata_i = '0;

  op_t      pending_ops[$];
  outcome_t expected_outcomes[$];
  int       err_cnt = 0;
  int       cyc = 0;

  // heap mirror
  logic [KeyPW-1:0] hp_key[Slots];
  logic [HdPW-1:0]  hp_hd[Slots];
  logic [HdPW-1:0]  hd_pos[Slots];
  bit               hd_live[Slots];
  int unsigned      hp_cnt = 0;
  int unsigned      cap_lim = 64;

  indexed_min_heap_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KeyPW-1:0] k;
    logic [HdPW-1:0]  h;
    k = hp_key[a];
    h = hp_hd[a];
    hp_key[a] = hp_key[b];
    hp_hd[a] = hp_hd[b];
    hp_key[b] = k;
    hp_hd[b] = h;
    hd_pos[hp_hd[a]] = HdPW'(a);
    hd_pos[hp_hd[b]] = HdPW'(b);
  endfunction

  function automatic void climb(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(hp_key[i] < hp_key[p])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sink(int unsigned i);
    int unsigned l, c;
    forever begin
      l = 2 * i + 1;
      if (l >= hp_cnt) break;
      c = l;
      // ties go to the right child
      if (l + 1 < hp_cnt && hp_key[l] >= hp_key[l + 1]) c = l + 1;
      if (!(hp_key[i] > hp_key[c])) break;
      swap_slots(i, c);
      i = c;
    end
  endfunction

  function automatic outcome_t heap_apply(op_t op);
    outcome_t    r;
    int unsigned lim, h, pos, last;
    lim = (cap_lim < 1) ? 1 : (cap_lim > Slots ? Slots : cap_lim);
    r.status = ST_OK;
    r.key = op.key;
    r.hd = '0;
    case (op.act)
      ACT_ENQ: begin
        if (hp_cnt >= lim) begin
          r.status = ST_FULL;
        end else begin
          h = 0;
          while (h < Slots - 1 && hd_live[h]) h++;
          hd_live[h] = 1'b1;
          pos = hp_cnt;
          hp_key[pos] = op.key;
          hp_hd[pos] = HdPW'(h);
          hd_pos[h] = HdPW'(pos);
          hp_cnt++;
          climb(pos);
          r.hd = HdPW'(h);
        end
      end
      ACT_DEQ: begin
        if (hp_cnt == 0) begin
          r.status = ST_EMPTY;
          r.key = '0;
        end else begin
          last = hp_cnt - 1;
          r.key = hp_key[0];
          r.hd = hp_hd[0];
          hd_live[r.hd] = 1'b0;
          if (last > 0) begin
            hp_key[0] = hp_key[last];
            hp_hd[0] = hp_hd[last];
            hd_pos[hp_hd[0]] = '0;
          end
          hp_cnt = last;
          sink(0);
        end
      end
      ACT_DEC: begin
        r.hd = op.hd;
        if (!hd_live[op.hd] || hd_pos[op.hd] >= hp_cnt) begin
          r.status = ST_DEAD;
        end else if (op.key > hp_key[hd_pos[op.hd]]) begin
          r.status = ST_KEY_INC;
        end else begin
          hp_key[hd_pos[op.hd]] = op.key;
          climb(32'(hd_pos[op.hd]));
        end
      end
      default: ;
    endcase
    r.cnt = CntPW'(hp_cnt);
    return r;
  endfunction

  // cycle counter; idling is off for a long stretch in the middle
  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic bit stall_now();
    if (cyc > 6000 && cyc < 11000) return 1'b0;
    return $urandom_range(99) < 18;
  endfunction

  // input driver, predicts on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    op_t o;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        o.hd = s_axis_tdata[39:34];
        o.key = s_axis_tdata[33:2];
        o.act = act_e'(s_axis_tdata[1:0]);
        expected_outcomes.push_back(heap_apply(o));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() > 0 && !stall_now()) begin
          o = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {o.hd, o.key, o.act};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          err_cnt++;
        end else begin
          e = expected_outcomes.pop_front();
          if (m_axis_tdata[2:0] !== e.status) begin
            $error("status exp %0d got %0d", e.status, m_axis_tdata[2:0]);
            err_cnt++;
          end
          if (m_axis_tdata[34:3] !== e.key) begin
            $error("key_out exp %h got %h", e.key, m_axis_tdata[34:3]);
            err_cnt++;
          end
          if (m_axis_tdata[40:35] !== e.hd) begin
            $error("handle_out exp %0d got %0d", e.hd, m_axis_tdata[40:35]);
            err_cnt++;
          end
          if (m_axis_tdata[47:41] !== e.cnt) begin
            $error("count exp %0d got %0d", e.cnt, m_axis_tdata[47:41]);
            err_cnt++;
          end
        end
      end
      m_axis_tready <= !stall_now();
    end
  end

  function automatic void add_op(act_e a, logic [KeyPW-1:0] k, logic [HdPW-1:0] h);
    op_t o;
    o.act = a;
    o.key = k;
    o.hd = h;
    pending_ops.push_back(o);
  endfunction

  function automatic logic [KeyPW-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  // wait until every beat is sent and answered, sampled away from the edge
  task automatic drain();
    @(negedge clk_i);
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
      @(negedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [LimW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_lim = 32'(v);
  endtask

  // random ops, enqueue share high first then low
  task automatic random_phase(int n);
    int r, fill;
    for (int i = 0; i < n; i++) begin
      fill = (i < n / 2) ? 60 : 30;
      r = $urandom_range(99);
      if (r < fill) add_op(ACT_ENQ, pick_key(), HdPW'($urandom));
      else if (r < fill + 22) add_op(ACT_DEQ, pick_key(), HdPW'($urandom));
      else if (r < 97)
        add_op(ACT_DEC, $urandom_range(1) ? $urandom_range(500) : $urandom,
               HdPW'(($urandom_range(9) < 8) ? $urandom_range(20) : $urandom_range(63)));
      else add_op(ACT_IGNORE, $urandom, HdPW'($urandom));
    end
  endtask

  initial begin
    logic [LimW-1:0] lims[10] = '{64, 1, 0, 3, 127, 17, 64, 100, 2, 65};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty, dead handle, extremes, ties, decrease cases, unused op
    add_op(ACT_DEQ, 32'hFFFF_FFFF, 6'h3F);
    add_op(ACT_DEC, 32'h0, 6'd0);
    add_op(ACT_ENQ, 32'hFFFF_FFFF, 6'h3F);
    add_op(ACT_ENQ, 32'h0, 6'h0);
    add_op(ACT_ENQ, 32'd5, 6'h0);
    add_op(ACT_ENQ, 32'd5, 6'h0);
    add_op(ACT_ENQ, 32'd5, 6'h0);
    add_op(ACT_DEC, 32'd5, 6'd2);
    add_op(ACT_DEC, 32'd9, 6'd2);
    add_op(ACT_DEC, 32'd0, 6'd0);
    add_op(ACT_DEC, 32'h0, 6'h3F);
    add_op(ACT_IGNORE, 32'hA5A5_5A5A, 6'h2A);
    repeat (6) add_op(ACT_DEQ, 32'h0, 6'h0);
    set_limit(7'd1);
    add_op(ACT_ENQ, 32'd7, 6'h0);
    add_op(ACT_ENQ, 32'd8, 6'h0);
    add_op(ACT_DEQ, 32'd0, 6'h0);
    foreach (lims[i]) begin
      set_limit(lims[i]);
      random_phase(155);
    end
    drain();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
design/imhq_pkg.sv
design/imhq_front.sv
design/imhq_back.sv
design/indexed_min_heap_queue.sv
tb/tb_top.sv
